>>> hdl/mmtt_pkg.sv
// Package for the multi-mode timer table: sizes, codes, and the transaction,
// chain token and cell control types.
// It has no dependencies; every module of the block imports it.
package mmtt_pkg;

	localparam int SLOTS   = 8;
	localparam int TIME_W  = 32;
	localparam int MAX_RES = 8;
	localparam int PRED_W  = 8;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int NRES_W  = $clog2(MAX_RES + 1);

	localparam logic [15:0] LATE_RESET = 16'd10;

	localparam logic [1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_UNTIL    = 2'd2;
	localparam logic [1:0] MODE_WHILE    = 2'd3;

	localparam logic [2:0] KIND_FIRED      = 3'd0;
	localparam logic [2:0] KIND_EXPIRED    = 3'd1;
	localparam logic [2:0] KIND_REGISTERED = 3'd2;
	localparam logic [2:0] KIND_FULL       = 3'd3;
	localparam logic [2:0] KIND_NONE       = 3'd4;

	localparam logic CMD_TICK     = 1'b0;
	localparam logic CMD_REGISTER = 1'b1;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  mode;
		logic [31:0] at_time;
		logic [15:0] period;
		logic [7:0]  pred_mask;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic        released;
		logic        late;
		logic [31:0] stamp;
		logic        last;
	} res_t;

	typedef struct packed {
		logic      vld;
		slot_idx_t idx;
		time_t     due;
		logic [1:0] mode;
		logic      end_hit;
	} tok_t;

	typedef struct packed {
		logic wr;
		logic hit;
		logic set_anchor;
		logic free_slot;
		logic clr_done;
	} cell_ctl_t;

endpackage

>>> hdl/mmtt_cell.sv
// One timer slot of the table and one link of the earliest-due search chain.
// Depends on mmtt_pkg for the slot, token and control types.
module mmtt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mmtt_pkg::slot_idx_t my_idx,
	input  mmtt_pkg::cell_ctl_t ctl,
	input  logic [1:0]        wr_mode,
	input  mmtt_pkg::time_t   wr_limit,
	input  logic [15:0]       wr_period,
	input  mmtt_pkg::time_t   now,
	input  mmtt_pkg::tok_t    tok_in,
	output mmtt_pkg::tok_t    tok_q,
	output logic              valid_q
);
	import mmtt_pkg::*;

	logic        done_q;
	logic [1:0]  mode_q;
	time_t       anchor_q;
	logic [15:0] period_q;
	time_t       limit_q;
	time_t       due_q;

	logic [TIME_W:0] sum;
	time_t           due_next;
	logic            elig;
	logic            take;

	assign sum      = {1'b0, anchor_q} + (TIME_W + 1)'(period_q);
	assign due_next = (mode_q == MODE_ONESHOT) ? limit_q :
		(sum[TIME_W] ? '1 : sum[TIME_W-1:0]);
	assign elig     = valid_q && !done_q && (due_q <= now);
	assign take     = elig && (!tok_in.vld || (due_q < tok_in.due));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (ctl.wr) begin
				valid_q <= 1'b1;
			end else if (ctl.hit && ctl.free_slot) begin
				valid_q <= 1'b0;
			end
			if (ctl.clr_done) begin
				done_q <= 1'b0;
			end else if (ctl.hit) begin
				done_q <= 1'b1;
			end
			if (take) begin
				tok_q <= '{vld: 1'b1, idx: my_idx, due: due_q, mode: mode_q,
					end_hit: (now >= limit_q)};
			end else begin
				tok_q <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mode_q   <= wr_mode;
			anchor_q <= now;
			period_q <= wr_period;
			limit_q  <= wr_limit;
		end else if (ctl.hit && ctl.set_anchor) begin
			anchor_q <= now;
		end
		due_q <= due_next;
	end

endmodule

>>> hdl/multi_mode_timer_table_core.sv
// Top level of the multi-mode timer table: sequencer, time counter and the row
// of slot cells. Depends on mmtt_pkg and mmtt_cell.
//
// Usage: a transaction on the request channel is taken at a clock edge with
// start high and busy low. A register request claims the lowest free slot and
// answers in the next cycle with a single result (registered or table full);
// busy stays low, so another request may follow in the next cycle.
// A tick advances the time counter and then handles due slots one at a time.
// Each handling step is a search along the cell row: the best candidate moves
// one cell per cycle. A tick ends with a final search that finds no due slot,
// unless eight slots were handled; then that empty search is replaced by a
// flush state. Results appear one per step, the last one flagged. Each result
// is shown for one cycle with res_valid and cannot be stalled by the receiver.
// The configuration channel is always ready and is meant to be written only
// while the block is idle.
// Reset clears the time counter, frees every slot and restores the late
// limit to ten ticks.
module multi_mode_timer_table_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mmtt_pkg::req_t req,
	output logic           res_valid,
	output mmtt_pkg::res_t res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);
	import mmtt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SETTLE = 4'b0010,
		ST_HANDLE = 4'b0100,
		ST_FLUSH  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NRES_W-1:0] n_q;
	logic              pend_vld_q;
	res_t              pend_q;
	logic [PRED_W-1:0] pred_q;
	time_t             now_q;
	logic [15:0]       late_lim_q;
	logic              res_valid_q;
	res_t              res_q;

	tok_t      tok [SLOTS];
	tok_t      tail;
	logic      valid [SLOTS];
	cell_ctl_t ctl [SLOTS];

	logic      accept;
	logic      free_found;
	slot_idx_t free_idx;
	logic      set_anchor;
	logic      rel;
	logic      fired;
	logic      pred_hit;
	time_t     lateness;
	res_t      new_res;
	logic      emit;
	res_t      emit_data;
	logic      pend_load;

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			mmtt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.my_idx    (slot_idx_t'(g)),
				.ctl       (ctl[g]),
				.wr_mode   (req.mode),
				.wr_limit  (time_t'(req.at_time)),
				.wr_period (req.period),
				.now       (now_q),
				.tok_in    ((g == 0) ? tok_t'('0) : tok[(g == 0) ? 0 : g - 1]),
				.tok_q     (tok[g]),
				.valid_q   (valid[g])
			);
		end
	endgenerate

	assign tail      = tok[SLOTS-1];
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				free_found = 1'b1;
				free_idx   = slot_idx_t'(i);
			end
		end
	end

	assign pred_hit = (32'(tail.idx) < PRED_W) && pred_q[3'(tail.idx)];

	always_comb begin
		set_anchor = 1'b0;
		rel        = 1'b0;
		fired      = 1'b1;
		unique case (tail.mode)
			MODE_ONESHOT: begin
				rel = 1'b1;
			end
			MODE_PERIODIC: begin
				set_anchor = 1'b1;
			end
			MODE_UNTIL: begin
				set_anchor = 1'b1;
				if (tail.end_hit) begin
					rel   = 1'b1;
					fired = 1'b0;
				end
			end
			MODE_WHILE: begin
				if (pred_hit) begin
					set_anchor = 1'b1;
				end else begin
					rel = 1'b1;
				end
			end
			default: begin
				rel = 1'b1;
			end
		endcase
	end

	assign lateness = now_q - tail.due;

	always_comb begin
		new_res          = '0;
		new_res.kind     = fired ? KIND_FIRED : KIND_EXPIRED;
		new_res.slot     = 3'(tail.idx);
		new_res.released = rel;
		new_res.late     = fired && (lateness > time_t'(late_lim_q));
		new_res.stamp    = 32'(now_q);
		new_res.last     = 1'b0;
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			ctl[i].wr         = accept && (req.cmd == CMD_REGISTER) && free_found &&
				(free_idx == slot_idx_t'(i));
			ctl[i].hit        = (state_q == ST_HANDLE) && tail.vld &&
				(tail.idx == slot_idx_t'(i));
			ctl[i].set_anchor = set_anchor;
			ctl[i].free_slot  = rel;
			ctl[i].clr_done   = accept && (req.cmd == CMD_TICK);
		end
	end

	always_comb begin
		emit           = 1'b0;
		pend_load      = 1'b0;
		emit_data      = pend_q;
		emit_data.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.cmd == CMD_REGISTER)) begin
					emit            = 1'b1;
					emit_data       = '0;
					emit_data.stamp = 32'(now_q);
					emit_data.last  = 1'b1;
					if (free_found) begin
						emit_data.kind = KIND_REGISTERED;
						emit_data.slot = 3'(free_idx);
					end else begin
						emit_data.kind = KIND_FULL;
					end
				end
			end
			ST_SETTLE: begin
				emit = 1'b0;
			end
			ST_HANDLE: begin
				if (tail.vld) begin
					emit           = pend_vld_q;
					emit_data.last = 1'b0;
					pend_load      = 1'b1;
				end else begin
					emit = 1'b1;
					if (!pend_vld_q) begin
						emit_data       = '0;
						emit_data.kind  = KIND_NONE;
						emit_data.stamp = 32'(now_q);
						emit_data.last  = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				emit = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			pend_vld_q  <= 1'b0;
			now_q       <= '0;
			late_lim_q  <= LATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
			if (cfg_valid && cfg_ready) begin
				late_lim_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req.cmd == CMD_TICK)) begin
						now_q      <= now_q + time_t'(1);
						cnt_q      <= '0;
						n_q        <= '0;
						pend_vld_q <= 1'b0;
						state_q    <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					if (cnt_q == CNT_W'(SLOTS)) begin
						state_q <= ST_HANDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_HANDLE: begin
					if (tail.vld) begin
						pend_vld_q <= 1'b1;
						n_q        <= n_q + NRES_W'(1);
						cnt_q      <= '0;
						if (n_q == NRES_W'(MAX_RES - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_SETTLE;
						end
					end else begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.cmd == CMD_TICK)) begin
			pred_q <= req.pred_mask;
		end
		if (pend_load) begin
			pend_q <= new_res;
		end
		if (emit) begin
			res_q <= emit_data;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_REGISTER) |=> res_valid && res.last && !busy)
		else $error("register transaction did not answer in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.cmd == CMD_TICK) |=> busy && !res_valid)
		else $error("tick transaction did not start the slot search");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("non-final result after the tick finished");

	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NRES_W'(MAX_RES))
		else $error("more slots handled in one tick than allowed");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_EXPIRED) |-> res.released && !res.late)
		else $error("expired slot result is inconsistent");
`endif

endmodule
